@@ rtl/vcc_pkg.sv @@
// Shared types, constants and letter mapping for the Cyrillic Vigenere unit.
package vcc_pkg;

    localparam int KEY_DEPTH   = 32;
    localparam int ALPHA_SIZE  = 33;
    localparam int KEY_ADDR_W  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KEY_LEN_W   = $clog2(KEY_DEPTH + 1);
    localparam int LETTER_W    = 6;
    localparam int CODE_W      = 16;
    localparam int KEY_COUNT_W = 6;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_ENCRYPT = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_KEY_EMPTY  = 2'd1,
        ST_KEY_FULL   = 2'd2,
        ST_NOT_LETTER = 2'd3
    } status_t;

    // Decoded letter: idx is the small-letter alphabet index 0..32
    typedef struct packed {
        logic                is_letter;
        logic                upper;
        logic [LETTER_W-1:0] idx;
    } letter_t;

    // Request state handed from the key stage to the shift stage
    typedef struct packed {
        logic                   enc;
        logic                   upper;
        logic [LETTER_W-1:0]    idx;
        logic [CODE_W-1:0]      code_point;
        status_t                status;
        logic [KEY_COUNT_W-1:0] key_count;
    } item_t;

    // Alphabet order: a..ie (0..5), io (6), zhe..ya (7..32)
    function automatic letter_t letter_decode(input logic [CODE_W-1:0] cu);
        letter_t l;
        l.is_letter = 1'b1;
        l.upper     = 1'b0;
        l.idx       = '0;
        if (cu >= 16'h0430 && cu <= 16'h0435) begin
            l.idx = LETTER_W'(cu - 16'h0430);
        end else if (cu == 16'h0451) begin
            l.idx = LETTER_W'(6);
        end else if (cu >= 16'h0436 && cu <= 16'h044F) begin
            l.idx = LETTER_W'(cu - 16'h042F);
        end else if (cu >= 16'h0410 && cu <= 16'h0415) begin
            l.upper = 1'b1;
            l.idx   = LETTER_W'(cu - 16'h0410);
        end else if (cu == 16'h0401) begin
            l.upper = 1'b1;
            l.idx   = LETTER_W'(6);
        end else if (cu >= 16'h0416 && cu <= 16'h042F) begin
            l.upper = 1'b1;
            l.idx   = LETTER_W'(cu - 16'h040F);
        end else begin
            l.is_letter = 1'b0;
        end
        return l;
    endfunction

    function automatic logic [CODE_W-1:0] letter_encode(input logic [LETTER_W-1:0] idx,
                                                        input logic upper);
        logic [CODE_W-1:0] base;
        logic [CODE_W-1:0] code;
        base = upper ? 16'h0410 : 16'h0430;
        if (idx < LETTER_W'(6)) begin
            code = base + CODE_W'(idx);
        end else if (idx == LETTER_W'(6)) begin
            code = upper ? 16'h0401 : 16'h0451;
        end else begin
            code = base + CODE_W'(idx) - 16'd1;
        end
        return code;
    endfunction

endpackage

@@ rtl/vcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module vcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/vcc_key_ctrl.sv @@
// Key stage: command decode, key length/position update and key store access.
module vcc_key_ctrl
    import vcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  cmd_t                cmd,
    input  logic [CODE_W-1:0]   code_point,
    output item_t               item,
    output logic [LETTER_W-1:0] key_letter
);

    logic [KEY_LEN_W-1:0]  len_reg, len_next;
    logic [KEY_ADDR_W-1:0] pos_reg, pos_next;
    logic [KEY_ADDR_W-1:0] pos_use;
    logic [KEY_LEN_W-1:0]  pos_inc;
    letter_t               letter;
    logic                  we;

    always_comb
    begin
        letter  = letter_decode(code_point);
        // position past length cannot happen, but treat it as zero
        pos_use = (KEY_LEN_W'(pos_reg) >= len_reg) ? '0 : pos_reg;
        pos_inc = KEY_LEN_W'(pos_use) + KEY_LEN_W'(1);

        len_next        = len_reg;
        pos_next        = pos_reg;
        we              = 1'b0;
        item.enc        = 1'b0;
        item.upper      = letter.upper;
        item.idx        = letter.idx;
        item.code_point = code_point;
        item.status     = ST_OK;

        unique case (cmd)
            CMD_CLEAR:
            begin
                len_next = '0;
                pos_next = '0;
            end
            CMD_APPEND:
            begin
                if (!letter.is_letter)
                begin
                    item.status = ST_NOT_LETTER;
                end
                else if (len_reg >= KEY_LEN_W'(KEY_DEPTH))
                begin
                    item.status = ST_KEY_FULL;
                end
                else
                begin
                    we       = 1'b1;
                    len_next = len_reg + KEY_LEN_W'(1);
                end
            end
            CMD_ENCRYPT:
            begin
                if (len_reg == '0)
                begin
                    item.status = ST_KEY_EMPTY;
                end
                else if (!letter.is_letter)
                begin
                    item.status = ST_NOT_LETTER;
                end
                else
                begin
                    item.enc = 1'b1;
                    pos_next = (pos_inc >= len_reg) ? '0 : pos_inc[KEY_ADDR_W-1:0];
                end
            end
            CMD_RESTART:
            begin
                pos_next = '0;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase

        item.key_count = KEY_COUNT_W'(len_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            pos_reg <= '0;
        end
        else if (accept)
        begin
            len_reg <= len_next;
            pos_reg <= pos_next;
        end
    end

    // Key letters are stored folded to small-letter indexes
    vcc_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (accept && we),
        .waddr (len_reg[KEY_ADDR_W-1:0]),
        .wdata (letter.idx),
        .re    (accept),
        .raddr (pos_use),
        .rdata (key_letter)
    );

endmodule

@@ rtl/vcc_shift.sv @@
// Shift stage: adds the key letter modulo 33 and re-encodes the code unit.
module vcc_shift
    import vcc_pkg::*;
(
    input  item_t               item,
    input  logic [LETTER_W-1:0] key_letter,
    output logic [CODE_W-1:0]   code_out
);

    logic [LETTER_W:0]   sum;
    logic [LETTER_W-1:0] shifted;

    always_comb
    begin
        sum     = {1'b0, item.idx} + {1'b0, key_letter};
        shifted = (sum >= (LETTER_W+1)'(ALPHA_SIZE))
                ? LETTER_W'(sum - (LETTER_W+1)'(ALPHA_SIZE))
                : sum[LETTER_W-1:0];
        code_out = item.enc ? letter_encode(shifted, item.upper) : item.code_point;
    end

endmodule

@@ rtl/vigenere_cipher_cyrillic_unit.sv @@
// Top level of the Cyrillic Vigenere stream cipher unit.
// Each request is held in s1_reg after its accept edge and then moves into the output register.
// Throughput: one request per cycle unless the master side stalls; the key update and key store
// read finish at the accept edge, the mod-33 shift and re-encode then load the output register.
// Reset (rst_n low, async) empties the key and zeroes the key position and pipeline
// valids; the key store itself is not cleared, only entries below the length are read.
module vigenere_cipher_cyrillic_unit
    import vcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_point
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] out_code_point, [21:16] key_count, [23:22] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic                accept;
    logic                advance;
    item_t               item;
    logic [LETTER_W-1:0] key_letter;
    logic [CODE_W-1:0]   code_out;

    logic                   s1_valid_reg;
    item_t                  s1_reg;
    logic                   out_valid_reg;
    logic [CODE_W-1:0]      out_code_reg;
    status_t                out_status_reg;
    logic [KEY_COUNT_W-1:0] out_count_reg;

    // Output register moves when empty or drained; the key stage moves when its
    // request can go forward (or it holds nothing).
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Key state update and key letter fetch happen at accept, so the next
    // request sees the updated position with no bubble.
    vcc_key_ctrl u_key_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd        (cmd_t'(s_tuser)),
        .code_point (s_tdata),
        .item       (item),
        .key_letter (key_letter)
    );

    // Key letter arrives from the RAM register aligned with s1_reg
    vcc_shift u_shift (
        .item       (s1_reg),
        .key_letter (key_letter),
        .code_out   (code_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= item;
        end
        if (advance && s1_valid_reg)
        begin
            out_code_reg   <= code_out;
            out_status_reg <= s1_reg.status;
            out_count_reg  <= s1_reg.key_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_code_reg};
    assign m_tuser  = out_status_reg;

endmodule

@@ rtl/vcc_checker.sv @@
// Port-level assertions for the Cyrillic Vigenere unit, bound to the top level.
module vcc_checker
    import vcc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // No result shows while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // Stalled result keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Full status only when the key store is at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_KEY_FULL) |-> m_tdata[21:16] == KEY_COUNT_W'(KEY_DEPTH))
        else $error("key full reported with spare room");

    // Empty-key status only when no key letters are stored
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_KEY_EMPTY) |-> m_tdata[21:16] == '0)
        else $error("key empty reported with stored letters");

    // Key count never grows past the store depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[21:16] <= KEY_COUNT_W'(KEY_DEPTH))
        else $error("key count out of range");

endmodule

bind vigenere_cipher_cyrillic_unit vcc_checker u_vcc_checker (.*);
